>>> src/lva_pkg.sv
package lva_pkg;

  localparam int NUM_VOICES_DEF = 8;
  localparam int NOTE_W         = 7;
  localparam int STAMP_W        = 32;
  localparam int OUTCOME_W      = 3;
  localparam int VOICE_W        = 6;

  localparam logic CMD_NOTE_ON  = 1'b0;
  localparam logic CMD_NOTE_OFF = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUTCOME_RETRIGGER = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_ALLOCATED = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_STOLEN    = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FREED     = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUTCOME_NO_VOICE  = 3'd4;

endpackage

>>> src/lva_ram.sv
module lva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lru_voice_allocator.sv
// lru voice allocator: each note-on beat is assigned to one of NUM_VOICES
// voices (retrigger, allocate oldest free or steal oldest busy), each note-off
// beat frees the oldest matching voice or reports no voice, and every beat
// gives exactly one result beat. The note and timestamp of every voice live in
// a ram that is scanned one voice per cycle, so a new event cannot be taken
// before the last one is through: in_stall stays high during the scan and
// while a finished result cannot yet be placed in the output register.
module lru_voice_allocator
  import lva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [NOTE_W-1:0]    in_note,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUTCOME_W-1:0] out_outcome,
  output logic [VOICE_W-1:0]   out_voice
);

  localparam int IW     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW     = $clog2(NUM_VOICES + 1) + 1;
  localparam int ENTRY_W = NOTE_W + STAMP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VOICES - 1);
  localparam logic [CW-1:0] NUM_C    = CW'(NUM_VOICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    cmd_r, cmd_nxt;
  logic [NOTE_W-1:0]       note_r, note_nxt;
  logic [STAMP_W-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]           iss_r, iss_nxt;
  logic                    dv_r, dv_nxt;
  logic [IW-1:0]           di_r, di_nxt;
  logic [NUM_VOICES-1:0]   busy_r, busy_nxt;
  logic [NUM_VOICES-1:0]   wr_r, wr_nxt;
  logic                    rt_found_r, rt_found_nxt;
  logic [IW-1:0]           rt_idx_r, rt_idx_nxt;
  logic                    fr_found_r, fr_found_nxt;
  logic [IW-1:0]           fr_idx_r, fr_idx_nxt;
  logic [STAMP_W-1:0]      fr_ts_r, fr_ts_nxt;
  logic                    bz_found_r, bz_found_nxt;
  logic [IW-1:0]           bz_idx_r, bz_idx_nxt;
  logic [STAMP_W-1:0]      bz_ts_r, bz_ts_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0]    out_outcome_r, out_outcome_nxt;
  logic [VOICE_W-1:0]      out_voice_r, out_voice_nxt;

  logic                    ram_we;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [IW-1:0]           pick;
  logic [OUTCOME_W-1:0]    pick_outcome;
  logic [STAMP_W-1:0]      cur_ts;
  logic [NOTE_W-1:0]       cur_note;
  logic                    cur_busy;
  logic                    cur_match;
  logic                    cur_lt;
  logic [STAMP_W-1:0]      sel_ts;
  logic                    out_free;
  logic                    issuing;

  lva_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick),
    .wdata ({note_r, cnt_r}),
    .raddr (iss_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_voice   = out_voice_r;

  assign out_free = !out_valid_r || !out_stall;
  assign issuing  = (state_r == ST_SCAN) && (iss_r < NUM_C);

  // never-written voices read as note 0, stamp 0
  assign cur_ts    = wr_r[di_r] ? ram_rdata[STAMP_W-1:0] : '0;
  assign cur_note  = wr_r[di_r] ? ram_rdata[ENTRY_W-1:STAMP_W] : '0;
  assign cur_busy  = busy_r[di_r];
  assign cur_match = cur_busy && (cur_note == note_r);
  assign sel_ts    = (cmd_r == CMD_NOTE_ON && !cur_busy) ? fr_ts_r : bz_ts_r;
  assign cur_lt    = cur_ts < sel_ts;

  always_comb begin
    pick         = '0;
    pick_outcome = OUTCOME_NO_VOICE;
    if (cmd_r == CMD_NOTE_ON) begin
      if (rt_found_r) begin
        pick         = rt_idx_r;
        pick_outcome = OUTCOME_RETRIGGER;
      end else if (fr_found_r) begin
        pick         = fr_idx_r;
        pick_outcome = OUTCOME_ALLOCATED;
      end else begin
        pick         = bz_idx_r;
        pick_outcome = OUTCOME_STOLEN;
      end
    end else if (bz_found_r) begin
      pick         = bz_idx_r;
      pick_outcome = OUTCOME_FREED;
    end
  end

  assign ram_we = (state_r == ST_FINISH) && out_free && (cmd_r == CMD_NOTE_ON);

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    note_nxt        = note_r;
    cnt_nxt         = cnt_r;
    iss_nxt         = iss_r;
    dv_nxt          = 1'b0;
    di_nxt          = di_r;
    busy_nxt        = busy_r;
    wr_nxt          = wr_r;
    rt_found_nxt    = rt_found_r;
    rt_idx_nxt      = rt_idx_r;
    fr_found_nxt    = fr_found_r;
    fr_idx_nxt      = fr_idx_r;
    fr_ts_nxt       = fr_ts_r;
    bz_found_nxt    = bz_found_r;
    bz_idx_nxt      = bz_idx_r;
    bz_ts_nxt       = bz_ts_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_outcome_nxt = out_outcome_r;
    out_voice_nxt   = out_voice_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          note_nxt     = in_note;
          iss_nxt      = '0;
          rt_found_nxt = 1'b0;
          fr_found_nxt = 1'b0;
          bz_found_nxt = 1'b0;
          if (in_cmd == CMD_NOTE_ON) begin
            cnt_nxt = cnt_r + STAMP_W'(1);
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          iss_nxt = iss_r + CW'(1);
          dv_nxt  = 1'b1;
          di_nxt  = iss_r[IW-1:0];
        end
        if (dv_r) begin
          if (cmd_r == CMD_NOTE_ON) begin
            if (cur_match && !rt_found_r) begin
              rt_found_nxt = 1'b1;
              rt_idx_nxt   = di_r;
            end
            if (!cur_busy) begin
              if (!fr_found_r || cur_lt) begin
                fr_found_nxt = 1'b1;
                fr_idx_nxt   = di_r;
                fr_ts_nxt    = cur_ts;
              end
            end else if (!bz_found_r || cur_lt) begin
              bz_found_nxt = 1'b1;
              bz_idx_nxt   = di_r;
              bz_ts_nxt    = cur_ts;
            end
          end else if (cur_match && (!bz_found_r || cur_lt)) begin
            bz_found_nxt = 1'b1;
            bz_idx_nxt   = di_r;
            bz_ts_nxt    = cur_ts;
          end
          if (di_r == LAST_IDX) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = pick_outcome;
          out_voice_nxt   = VOICE_W'(pick);
          if (cmd_r == CMD_NOTE_ON) begin
            busy_nxt[pick] = 1'b1;
            wr_nxt[pick]   = 1'b1;
          end else if (bz_found_r) begin
            busy_nxt[pick] = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      busy_r      <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      busy_r      <= busy_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    note_r        <= note_nxt;
    iss_r         <= iss_nxt;
    di_r          <= di_nxt;
    rt_found_r    <= rt_found_nxt;
    rt_idx_r      <= rt_idx_nxt;
    fr_found_r    <= fr_found_nxt;
    fr_idx_r      <= fr_idx_nxt;
    fr_ts_r       <= fr_ts_nxt;
    bz_found_r    <= bz_found_nxt;
    bz_idx_r      <= bz_idx_nxt;
    bz_ts_r       <= bz_ts_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_voice_r   <= out_voice_nxt;
  end

endmodule

>>> dv/tb_lru_voice_allocator.sv
module tb_lru_voice_allocator
  import lva_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV          = NUM_VOICES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [VOICE_W-1:0]   voice;
  } voice_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd;
  logic [NOTE_W-1:0]    in_note;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [VOICE_W-1:0]   out_voice;

  // predictor state
  logic                 held       [NV];
  logic [NOTE_W-1:0]    held_note  [NV];
  logic [STAMP_W-1:0]   last_touch [NV];
  logic [STAMP_W-1:0]   note_on_count;

  voice_result_t pending_results[$];
  voice_result_t want;
  int            errors;
  int            cycle_count;
  bit            idle_en;
  int            hold_req;
  int            hold_left;

  lru_voice_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_note    (in_note),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_outcome(out_outcome),
    .out_voice  (out_voice)
  );

  always #4 clk = ~clk;

  function automatic voice_result_t assign_voice(input logic cmd, input logic [NOTE_W-1:0] nt);
    voice_result_t      r;
    bit                 free_found;
    bit                 busy_found;
    int                 free_i;
    int                 busy_i;
    int                 pick;
    logic [STAMP_W-1:0] free_ts;
    logic [STAMP_W-1:0] busy_ts;
    free_found = 1'b0;
    busy_found = 1'b0;
    free_i = 0;
    busy_i = 0;
    free_ts = '0;
    busy_ts = '0;
    if (cmd == CMD_NOTE_ON) begin
      note_on_count = note_on_count + 1;
      for (int i = 0; i < NV; i++) begin
        if (held[i] && held_note[i] == nt) begin
          last_touch[i] = note_on_count;
          r.outcome = OUTCOME_RETRIGGER;
          r.voice = VOICE_W'(i);
          return r;
        end
      end
      for (int i = 0; i < NV; i++) begin
        if (!held[i]) begin
          if (!free_found || last_touch[i] < free_ts) begin
            free_found = 1'b1;
            free_ts = last_touch[i];
            free_i = i;
          end
        end else if (!busy_found || last_touch[i] < busy_ts) begin
          busy_found = 1'b1;
          busy_ts = last_touch[i];
          busy_i = i;
        end
      end
      pick = free_found ? free_i : busy_i;
      held[pick] = 1'b1;
      held_note[pick] = nt;
      last_touch[pick] = note_on_count;
      r.outcome = free_found ? OUTCOME_ALLOCATED : OUTCOME_STOLEN;
      r.voice = VOICE_W'(pick);
    end else begin
      for (int i = 0; i < NV; i++) begin
        if (held[i] && held_note[i] == nt) begin
          if (!busy_found || last_touch[i] < busy_ts) begin
            busy_found = 1'b1;
            busy_ts = last_touch[i];
            busy_i = i;
          end
        end
      end
      if (busy_found) begin
        held[busy_i] = 1'b0;
        r.outcome = OUTCOME_FREED;
        r.voice = VOICE_W'(busy_i);
      end else begin
        r.outcome = OUTCOME_NO_VOICE;
        r.voice = '0;
      end
    end
    return r;
  endfunction

  task automatic send_event(input logic cmd, input logic [NOTE_W-1:0] nt);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_note <= nt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(assign_voice(cmd, nt));
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // a note-off miss, then allocate, retrigger and steal with the extreme notes
  task automatic test_fill_and_steal();
    send_event(CMD_NOTE_OFF, 7'd0);
    send_event(CMD_NOTE_ON, 7'd0);
    send_event(CMD_NOTE_ON, 7'd127);
    send_event(CMD_NOTE_ON, 7'd0);
    for (int n = 10; n < 16; n++) send_event(CMD_NOTE_ON, NOTE_W'(n));
    send_event(CMD_NOTE_ON, 7'd127);
    send_event(CMD_NOTE_ON, 7'd64);
    send_event(CMD_NOTE_ON, 7'd85);
  endtask

  // free, miss, then reuse of freed voices by their old stamp
  task automatic test_note_off();
    send_event(CMD_NOTE_OFF, 7'd64);
    send_event(CMD_NOTE_OFF, 7'd64);
    send_event(CMD_NOTE_OFF, 7'd12);
    send_event(CMD_NOTE_OFF, 7'd127);
    send_event(CMD_NOTE_OFF, 7'd42);
    send_event(CMD_NOTE_ON, 7'd99);
    send_event(CMD_NOTE_ON, 7'd127);
    send_event(CMD_NOTE_ON, 7'd12);
    send_event(CMD_NOTE_ON, 7'd1);
  endtask

  task automatic test_output_holdoff();
    @(posedge clk);
    hold_req = 200;
    for (int i = 0; i < 12; i++) begin
      send_event($urandom_range(99) < 65 ? CMD_NOTE_ON : CMD_NOTE_OFF,
                 NOTE_W'($urandom_range(20, 31)));
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 8; i++) send_event(CMD_NOTE_ON, NOTE_W'(100 + i));
    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_drain();
    for (int i = 7; i >= 0; i -= 2) send_event(CMD_NOTE_OFF, NOTE_W'(100 + i));
    for (int i = 0; i < 4; i++) send_event(CMD_NOTE_ON, NOTE_W'(50 + i));
  endtask

  // mostly a small pool of notes so that retrigger, steal and free all hit
  task automatic test_random_mix(input int count);
    int                base;
    logic              cmd;
    logic [NOTE_W-1:0] nt;
    base = $urandom_range(0, 115);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 2) base = $urandom_range(0, 115);
      cmd = ($urandom_range(99) < 58) ? CMD_NOTE_ON : CMD_NOTE_OFF;
      if ($urandom_range(99) < 75) nt = NOTE_W'(base + $urandom_range(0, 12));
      else nt = NOTE_W'($urandom_range(0, 127));
      send_event(cmd, nt);
    end
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (idle_en) begin
      out_stall <= ($urandom_range(99) < 28);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, outcome %0d voice %0d",
                 $time, out_outcome, out_voice);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, out_outcome);
          errors++;
        end
        if (out_voice !== want.voice) begin
          $display("%0t: voice expected %0d actual %0d", $time, want.voice, out_voice);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NOTE_ON;
    in_note = '0;
    out_stall = 1'b0;
    errors = 0;
    cycle_count = 0;
    idle_en = 1'b1;
    hold_req = 0;
    hold_left = 0;
    note_on_count = '0;
    for (int i = 0; i < NV; i++) begin
      held[i] = 1'b0;
      held_note[i] = '0;
      last_touch[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_steal();
    test_note_off();
    test_output_holdoff();
    test_drain_pause();
    test_random_mix(650);
    idle_en = 1'b0;
    test_random_mix(200);
    idle_en = 1'b1;
    test_random_mix(150);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (NV + 8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
